// ===== hdl/run_length_string_encoder_top_defines.svh =====
// ---------------------------------------------------------------------------
// run-length string encoder assertion macros
// assertion wrappers for the checker module
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_STRING_ENCODER_TOP_DEFINES_SVH
`define RUN_LENGTH_STRING_ENCODER_TOP_DEFINES_SVH

// checked only outside reset
`define RLSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define RLSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rlse_pkg.sv =====
// ---------------------------------------------------------------------------
// rlse_pkg
// shared constants and types of the run-length string encoder
// ---------------------------------------------------------------------------
package rlse_pkg;

    localparam int COUNT_BITS   = 32;
    localparam int DELTA_W      = COUNT_BITS + 1;
    localparam int RUN_W        = 32;
    localparam int GROUP_BITS   = 5;
    localparam int CHAR_W       = 7;
    localparam int MAX_CHARS    = 7;
    localparam int CHAR_IDX_W   = $clog2(MAX_CHARS);
    localparam int POS_W        = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0]  POS_FIRST = 2'd0;
    localparam logic [POS_W-1:0]  POS_DELTA = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_BASE = 7'd48;

    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/rlse_front.sv =====
// ---------------------------------------------------------------------------
// rlse_front
// accepts counts, tracks mask position and forms the value to be coded
// ---------------------------------------------------------------------------
module rlse_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [rlse_pkg::RUN_W-1:0] s_tdata,
    input  logic                   s_tuser,
    input  rlse_pkg::q_status_t    q_status,
    output logic                   q_push,
    output rlse_pkg::delta_t       q_wdata
);
    import rlse_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    count_t           prev1_reg, prev2_reg;
    count_t           count;
    logic             accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign count    = s_tdata[COUNT_BITS-1:0];
    assign pos_eff  = s_tuser ? POS_FIRST : pos_reg;
    assign pos_next = (pos_eff == POS_DELTA) ? pos_eff : pos_eff + 1'b1;

    always_comb begin
        if (pos_eff == POS_DELTA) begin
            q_wdata = delta_t'({1'b0, count}) - delta_t'({1'b0, prev2_reg});
        end else begin
            q_wdata = delta_t'({1'b0, count});
        end
    end

    assign q_push = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_FIRST;
            prev1_reg <= '0;
            prev2_reg <= '0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            prev1_reg <= count;
            prev2_reg <= prev1_reg;
        end
    end

endmodule

// ===== hdl/rlse_queue.sv =====
// ---------------------------------------------------------------------------
// rlse_queue
// short queue of coded values between front and back end
// ---------------------------------------------------------------------------
module rlse_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rlse_pkg::delta_t    wdata,
    input  logic                pop,
    output rlse_pkg::delta_t    rdata,
    output rlse_pkg::q_status_t status
);
    import rlse_pkg::*;

    delta_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            priority if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rlse_back.sv =====
// ---------------------------------------------------------------------------
// rlse_back
// cuts each value into 5-bit groups and emits one character per beat
// ---------------------------------------------------------------------------
module rlse_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rlse_pkg::q_status_t       q_status,
    input  rlse_pkg::delta_t          q_rdata,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [rlse_pkg::CHAR_W-1:0] char_code,
    output logic                      m_tlast
);
    import rlse_pkg::*;

    delta_t                x_reg, x_shift;
    logic [CHAR_IDX_W-1:0] n_reg;
    logic                  busy_reg;
    logic                  out_valid_reg, last_reg;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic [GROUP_BITS-1:0] group;
    logic                  more, out_free, emit;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign q_pop    = !busy_reg && !q_status.empty;

    assign group   = x_reg[GROUP_BITS-1:0];
    assign x_shift = x_reg >>> GROUP_BITS;

    always_comb begin
        if (group[GROUP_BITS-1]) begin
            more = (x_shift != '1);
        end else begin
            more = (x_shift != '0);
        end
        if (n_reg == CHAR_IDX_W'(MAX_CHARS - 1)) begin
            more = 1'b0;
        end
        char_next = CHAR_W'({more, group}) + CHAR_BASE;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            x_reg <= q_rdata;
        end else if (emit) begin
            x_reg <= x_shift;
        end
        if (emit) begin
            char_reg <= char_next;
            last_reg <= !more;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                n_reg    <= '0;
            end else if (emit) begin
                n_reg <= n_reg + 1'b1;
                if (!more) begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign char_code = char_reg;
    assign m_tlast   = last_reg;

endmodule

// ===== hdl/run_length_string_encoder_top.sv =====
// ---------------------------------------------------------------------------
// run_length_string_encoder_top
// codes run-length counts as printable 5-bit group strings
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                         | tuser          | tlast
//  s_       | in  | [31:0] run_length             | first_of_mask  | -
//  m_       | out | [6:0] char_code, [7] zero     | -              | last_char
//
//  the back end loads each count from the queue and then emits one to seven
//  characters for it, taking the next count only once its last character is out
//  the front end takes a count per cycle until the two-entry queue fills
//  synchronous active-low reset clears mask position, recent counts, queue
//  a stalled m_ beat holds; the front end keeps accepting while the queue has room
// ---------------------------------------------------------------------------
module run_length_string_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] run_length
    input  logic        s_tuser,   // [0] first_of_mask
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast
);
    import rlse_pkg::*;

    q_status_t         q_status;
    logic              q_push, q_pop;
    delta_t            q_wdata, q_rdata;
    logic [CHAR_W-1:0] char_code;

    rlse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    rlse_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    rlse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .char_code (char_code),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {1'b0, char_code};

endmodule

// ===== hdl/rlse_checker.sv =====
// ---------------------------------------------------------------------------
// rlse_checker
// port-level checks of the run-length string encoder
// ---------------------------------------------------------------------------
`include "run_length_string_encoder_top_defines.svh"

module rlse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // no beat right after reset
    `RLSE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // stalled beat stays
    `RLSE_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")

    // final character carries no continuation bit
    `RLSE_ASSERT(a_last_range, aclk, aresetn, m_tvalid && m_tlast |-> m_tdata >= 8'd48 && m_tdata <= 8'd79, "bad final character")

    // other characters carry the continuation bit
    `RLSE_ASSERT(a_more_range, aclk, aresetn, m_tvalid && !m_tlast |-> m_tdata >= 8'd80 && m_tdata <= 8'd111, "bad continued character")

endmodule

bind run_length_string_encoder_top rlse_checker u_rlse_checker (.*);
